// File: rtl/lowest_free_id_allocator_core_macros.svh
// Assertion macros for the lowest free id allocator.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LOWEST_FREE_ID_ALLOCATOR_CORE_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_CORE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define LFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lfa_pkg.sv
// Shared types and constants of the lowest free id allocator.
// No dependencies; the files that use it refer to this package by scoped names.
`timescale 1ns / 1ps

package lfa_pkg;

    localparam int CUST_W = 10;
    localparam int ROOM_W = 9;
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    localparam logic MODE_ENTER = 1'b0;
    localparam logic MODE_LEAVE = 1'b1;

    typedef struct packed {
        logic load_in;
        logic find_rd;
        logic take;
        logic open_new;
        logic refuse;
        logic tab_rd;
        logic leave_chk;
        logic leave_skip;
        logic leave_set;
    } cmd_t;

    typedef struct packed {
        logic summ_any;
        logic can_open;
        logic leave_ok;
    } stat_t;

endpackage

// File: rtl/lfa_ifs.sv
// Request and result channel interfaces of the lowest free id allocator.
// Depends on lfa_pkg for the field widths.
`timescale 1ns / 1ps

interface lfa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [lfa_pkg::CUST_W-1:0] customer_id;

    modport source (output valid, output mode, output customer_id, input ready);
    modport sink   (input valid, input mode, input customer_id, output ready);
endinterface

interface lfa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [lfa_pkg::ROOM_W-1:0] room;
    logic [lfa_pkg::ROOM_W-1:0] rooms_open;
    logic                        status;

    modport source (output valid, output room, output rooms_open, output status,
                    input ready);
    modport sink   (input valid, input room, input rooms_open, input status,
                    output ready);
endinterface

// File: rtl/lfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/lfa_ctrl.sv
// Controller of the lowest free id allocator: sequences one request at a time
// and owns the handshakes. Depends on lfa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lowest_free_id_allocator_core_macros.svh"

module lfa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_mode,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  lfa_pkg::stat_t stat,
    output lfa_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_TAKE,
        ST_LREAD,
        ST_LCHECK,
        ST_LSET
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   load_out;
    logic [4:0] commit_vec;

    assign out_free   = !out_valid_reg || out_ready;
    assign commit_vec = {cmd.open_new, cmd.refuse, cmd.take, cmd.leave_skip, cmd.leave_set};
    assign load_out   = |commit_vec;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = (in_mode == lfa_pkg::MODE_LEAVE) ? ST_LREAD : ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (stat.summ_any)
                begin
                    cmd.find_rd = 1'b1;
                    state_next  = ST_TAKE;
                end
                else if (out_free)
                begin
                    cmd.open_new = stat.can_open;
                    cmd.refuse   = !stat.can_open;
                    state_next   = ST_IDLE;
                end
            end
            ST_TAKE:
            begin
                if (out_free)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LREAD:
            begin
                cmd.tab_rd = 1'b1;
                state_next = ST_LCHECK;
            end
            ST_LCHECK:
            begin
                if (stat.leave_ok)
                begin
                    cmd.leave_chk = 1'b1;
                    state_next    = ST_LSET;
                end
                else if (out_free)
                begin
                    cmd.leave_skip = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_LSET:
            begin
                if (out_free)
                begin
                    cmd.leave_set = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready_next  = (state_next == ST_IDLE);
    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    `LFA_ASSERT(a_commit_needs_slot, load_out |-> out_free, "result loaded over a pending one")
    `LFA_ASSERT(a_one_commit, $onehot0(commit_vec), "more than one commit at once")
    `LFA_ASSERT_NEXT(a_one_request, in_valid && in_ready_reg, !in_ready_reg,
        "second request accepted while busy")

endmodule

// File: rtl/lfa_dpath.sv
// Datapath of the lowest free id allocator: customer table RAM, free-room bitmap
// RAM with a per-word summary, open count and result register.
// Depends on lfa_pkg, lfa_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "lowest_free_id_allocator_core_macros.svh"

module lfa_dpath #(
    parameter int MAX_ROOMS     = 256,
    parameter int MAX_CUSTOMERS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfa_pkg::cmd_t               cmd,
    output lfa_pkg::stat_t              stat,
    input  logic [lfa_pkg::CUST_W-1:0]  customer_id,
    output logic [lfa_pkg::ROOM_W-1:0]  room,
    output logic [lfa_pkg::ROOM_W-1:0]  rooms_open,
    output logic                        status
);

    localparam int CW     = lfa_pkg::CUST_W;
    localparam int RW     = lfa_pkg::ROOM_W;
    localparam int WW     = lfa_pkg::WORD_W;
    localparam int BW     = lfa_pkg::BIT_W;
    localparam int CNT_W  = $clog2(MAX_ROOMS + 1);
    localparam int IDX_W  = $clog2(MAX_ROOMS);
    localparam int CID_W  = $clog2(MAX_CUSTOMERS);
    localparam int NWORDS = (MAX_ROOMS + WW - 1) / WW;
    localparam int WI_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int FI_W   = WI_W + BW;

    // id modulo table depth by conditional subtraction of shifted depths
    function automatic logic [CW-1:0] cid_wrap(input logic [CW-1:0] x);
        logic [CW-1:0] r;
        r = x;
        for (int k = CW - 1; k >= 0; k--)
        begin
            if ((MAX_CUSTOMERS << k) < (1 << CW))
            begin
                if (r >= CW'(MAX_CUSTOMERS << k))
                begin
                    r = r - CW'(MAX_CUSTOMERS << k);
                end
            end
        end
        return r;
    endfunction

    logic [CID_W-1:0]    cid_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NWORDS-1:0]   summ_reg;
    logic [FI_W-1:0]     idx_reg;
    logic [RW-1:0]       room_reg, room_next;
    logic [RW-1:0]       open_reg, open_next;
    logic                stat_reg, stat_next;

    logic [CID_W+CW-1:0] cid_ext;
    logic [CID_W-1:0]    cid_in;
    logic [WI_W-1:0]     sum_pe;
    logic [BW-1:0]       word_pe;
    logic [WW-1:0]       free_rdata, free_wdata;
    logic [WI_W-1:0]     free_waddr, free_raddr;
    logic                free_we, free_re;
    logic [IDX_W-1:0]    tab_rdata, tab_wdata;
    logic                tab_we;
    logic [FI_W-1:0]     lv_full, take_full;
    logic [WI_W-1:0]     idx_word;
    logic [BW-1:0]       idx_bit;
    logic [WW-1:0]       take_word, set_word;
    logic [CNT_W-1:0]    room_res;
    logic                load_out;
    logic [CNT_W+RW-1:0] room_ext, open_ext;

    assign cid_ext = {{CID_W{1'b0}}, cid_wrap(customer_id)};
    assign cid_in  = cid_ext[CID_W-1:0];

    always_comb
    begin
        sum_pe = '0;
        for (int i = NWORDS - 1; i >= 0; i--)
        begin
            if (summ_reg[i])
            begin
                sum_pe = WI_W'(i);
            end
        end
    end

    always_comb
    begin
        word_pe = '0;
        for (int i = WW - 1; i >= 0; i--)
        begin
            if (free_rdata[i])
            begin
                word_pe = BW'(i);
            end
        end
    end

    assign idx_word  = idx_reg[FI_W-1:BW];
    assign idx_bit   = idx_reg[BW-1:0];
    assign take_full = {idx_word, word_pe};
    assign lv_full   = FI_W'(tab_rdata);
    assign take_word = free_rdata & ~(WW'(1) << word_pe);
    assign set_word  = (summ_reg[idx_word] ? free_rdata : '0) | (WW'(1) << idx_bit);

    assign free_we    = cmd.take || cmd.leave_set;
    assign free_waddr = idx_word;
    assign free_wdata = cmd.take ? take_word : set_word;
    assign free_re    = cmd.find_rd || cmd.leave_chk;
    assign free_raddr = cmd.find_rd ? sum_pe : lv_full[FI_W-1:BW];

    assign tab_we    = cmd.open_new || cmd.take;
    assign tab_wdata = cmd.open_new ? cnt_reg[IDX_W-1:0] : take_full[IDX_W-1:0];

    lfa_ram #(
        .WIDTH (WW),
        .DEPTH (NWORDS)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .re    (free_re),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    lfa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_CUSTOMERS)
    ) u_tab_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (cid_reg),
        .wdata (tab_wdata),
        .re    (cmd.tab_rd),
        .raddr (cid_reg),
        .rdata (tab_rdata)
    );

    assign stat.summ_any = |summ_reg;
    assign stat.can_open = (cnt_reg < CNT_W'(MAX_ROOMS));
    assign stat.leave_ok = (CNT_W'(tab_rdata) < cnt_reg);

    assign cnt_next = cmd.open_new ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign load_out = cmd.open_new || cmd.refuse || cmd.take || cmd.leave_skip
                      || cmd.leave_set;

    always_comb
    begin
        room_res = '0;
        if (cmd.open_new)
        begin
            room_res = cnt_reg + CNT_W'(1);
        end
        else if (cmd.take)
        begin
            room_res = CNT_W'(take_full) + CNT_W'(1);
        end
        else if (cmd.leave_set)
        begin
            room_res = CNT_W'(idx_reg) + CNT_W'(1);
        end
    end

    assign room_ext  = {{RW{1'b0}}, room_res};
    assign open_ext  = {{RW{1'b0}}, cnt_next};
    assign room_next = room_ext[RW-1:0];
    assign open_next = open_ext[RW-1:0];
    assign stat_next = cmd.refuse;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            summ_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.take)
            begin
                summ_reg[idx_word] <= |take_word;
            end
            else if (cmd.leave_set)
            begin
                summ_reg[idx_word] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cid_reg <= cid_in;
        end
        if (cmd.find_rd)
        begin
            idx_reg <= {sum_pe, {BW{1'b0}}};
        end
        else if (cmd.leave_chk)
        begin
            idx_reg <= lv_full;
        end
        if (load_out)
        begin
            room_reg <= room_next;
            open_reg <= open_next;
            stat_reg <= stat_next;
        end
    end

    assign room       = room_reg;
    assign rooms_open = open_reg;
    assign status     = stat_reg;

    `LFA_ASSERT(a_take_word_nonzero, cmd.take |-> (free_rdata != '0),
        "summary marked a word free that holds no free room")
    `LFA_ASSERT(a_count_bound, cnt_reg <= CNT_W'(MAX_ROOMS), "open count beyond room limit")
    `LFA_ASSERT(a_open_only_when_none_free, cmd.open_new |-> !(|summ_reg),
        "new room opened while a released room exists")

endmodule

// File: rtl/lowest_free_id_allocator_core.sv
// Lowest free id allocator: one request in, one result out. An enter request is
// given the lowest released room, else a newly opened room, else a full status;
// a leave request releases the room recorded for its customer. An enter that
// opens a room or is refused loads its result without a RAM read; an enter that
// reuses a released room first reads its word of the free-room bitmap RAM. A
// leave first reads the customer table RAM; if the recorded room was never opened
// its result is then loaded, else it reads the bitmap word and loads its result.
// The next request is taken on the cycle after the result is loaded, so a new
// request is never taken before the result of the last one is loaded. Both
// RAMs have registered reads. A result register holds the last result
// so that a new request can be taken while it waits; the next result load stalls
// until the sink has taken it. No clearing pass after reset: a per-word summary
// marks which bitmap words hold released rooms.
// Depends on lfa_pkg, lfa_ifs, lfa_ctrl and lfa_dpath.
`timescale 1ns / 1ps

module lowest_free_id_allocator_core #(
    parameter int MAX_ROOMS     = 256,
    parameter int MAX_CUSTOMERS = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    lfa_req_if.sink   req,
    lfa_rsp_if.source rsp
);

    lfa_pkg::cmd_t  cmd;
    lfa_pkg::stat_t stat;

    lfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_mode   (req.mode),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lfa_dpath #(
        .MAX_ROOMS     (MAX_ROOMS),
        .MAX_CUSTOMERS (MAX_CUSTOMERS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .customer_id (req.customer_id),
        .room        (rsp.room),
        .rooms_open  (rsp.rooms_open),
        .status      (rsp.status)
    );

endmodule

// File: test/lowest_free_id_allocator_core_tb.sv
// Testbench for lowest_free_id_allocator_core: directed and random enter/leave requests,
// each result checked against an in-bench room allocator, with random gaps and stalls.
// Depends on lfa_pkg, lfa_ifs and the allocator RTL.
`timescale 1ns / 1ps

module lowest_free_id_allocator_core_tb;

    localparam int MAX_ROOMS     = 256;
    localparam int MAX_CUSTOMERS = 1024;
    localparam int RANDOM_REQS   = 1000;

    typedef struct packed {
        logic [lfa_pkg::ROOM_W-1:0] room;
        logic [lfa_pkg::ROOM_W-1:0] rooms_open;
        logic                       status;
    } room_result_t;

    class room_book;
        logic [7:0]   seat_room [MAX_CUSTOMERS];
        bit           seated    [MAX_CUSTOMERS];
        bit           released  [MAX_ROOMS];
        int unsigned  opened;
        int unsigned  known_ids[$];
        room_result_t due[$];
        int           errors, n_enter, n_leave, n_reuse, n_refused;

        function new();
            opened = 0;
            errors = 0;
            n_enter = 0;
            n_leave = 0;
            n_reuse = 0;
            n_refused = 0;
            foreach (seated[i]) seated[i] = 1'b0;
            foreach (released[i]) released[i] = 1'b0;
        endfunction

        function void log_request(logic mode, logic [lfa_pkg::CUST_W-1:0] cid);
            room_result_t r;
            int unsigned  i;
            r = '0;
            if (mode == lfa_pkg::MODE_ENTER)
            begin
                n_enter++;
                i = 0;
                while (i < opened && !released[i]) i++;
                if (i < opened)
                begin
                    released[i] = 1'b0;
                    seat_room[cid] = i[7:0];
                    r.room = 9'(i + 1);
                    n_reuse++;
                end
                else if (opened < MAX_ROOMS)
                begin
                    seat_room[cid] = opened[7:0];
                    opened++;
                    r.room = 9'(opened);
                end
                else
                begin
                    r.status = 1'b1;
                    n_refused++;
                end
                if (!r.status && !seated[cid])
                begin
                    seated[cid] = 1'b1;
                    known_ids.push_back(cid);
                end
            end
            else
            begin
                n_leave++;
                i = seat_room[cid];
                if (i < opened)
                begin
                    released[i] = 1'b1;
                    r.room = 9'(i + 1);
                end
            end
            r.rooms_open = 9'(opened);
            due.push_back(r);
        endfunction

        function void match_result(logic [8:0] room, logic [8:0] rooms_open, logic status);
            room_result_t want;
            if (due.size() == 0)
            begin
                $display("%0t: unexpected result room=%0d rooms_open=%0d status=%0d",
                         $time, room, rooms_open, status);
                errors++;
                return;
            end
            want = due.pop_front();
            if (room !== want.room)
            begin
                $display("%0t: room expected %0d got %0d", $time, want.room, room);
                errors++;
            end
            if (rooms_open !== want.rooms_open)
            begin
                $display("%0t: rooms_open expected %0d got %0d", $time, want.rooms_open,
                         rooms_open);
                errors++;
            end
            if (status !== want.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     sink_ready = 1'b0;
    int       stall_cycle = 0;
    int       stall_kind = 0;
    int       burst_left = 0;
    room_book book;

    lfa_req_if req_ch ();
    lfa_rsp_if rsp_ch ();

    assign rsp_ch.ready = sink_ready;

    lowest_free_id_allocator_core #(
        .MAX_ROOMS     (MAX_ROOMS),
        .MAX_CUSTOMERS (MAX_CUSTOMERS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // result sink: check, then pick the next ready value from the current stall pattern
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            book.match_result(rsp_ch.room, rsp_ch.rooms_open, rsp_ch.status);
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 64 == 0)
            stall_kind <= $urandom_range(0, 3);
        if (!rst_n)
            sink_ready <= 1'b0;
        else
            case (stall_kind)
                0:       sink_ready <= 1'b1;
                1:       sink_ready <= 1'($urandom_range(0, 1));
                2:       sink_ready <= (stall_cycle % 4 == 0);
                default: sink_ready <= (stall_cycle % 16 < 10);
            endcase
    end

    task automatic send_request(input logic mode, input logic [lfa_pkg::CUST_W-1:0] cid);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= mode;
        req_ch.customer_id <= cid;
        do @(posedge clk); while (!req_ch.ready);
        book.log_request(mode, cid);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    initial
    begin
        #2ms;
        $display("timeout with %0d results outstanding", book.due.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic                       mode;
        logic [lfa_pkg::CUST_W-1:0] cid;
        int                         p_enter;

        book = new();
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= lfa_pkg::MODE_ENTER;
        req_ch.customer_id <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(lfa_pkg::MODE_ENTER, 10'd0);
        send_request(lfa_pkg::MODE_ENTER, 10'd1023);
        send_request(lfa_pkg::MODE_LEAVE, 10'd0);
        send_request(lfa_pkg::MODE_LEAVE, 10'd0);     // repeated leave
        send_request(lfa_pkg::MODE_ENTER, 10'd512);   // takes the released room
        send_request(lfa_pkg::MODE_ENTER, 10'h155);
        send_request(lfa_pkg::MODE_ENTER, 10'h2aa);
        send_request(lfa_pkg::MODE_LEAVE, 10'd1023);
        send_request(lfa_pkg::MODE_LEAVE, 10'h155);
        send_request(lfa_pkg::MODE_ENTER, 10'd1);     // lowest of two released rooms
        send_request(lfa_pkg::MODE_ENTER, 10'd2);
        send_request(lfa_pkg::MODE_ENTER, 10'd4);
        send_request(lfa_pkg::MODE_LEAVE, 10'd512);
        send_request(lfa_pkg::MODE_LEAVE, 10'h2aa);
        send_request(lfa_pkg::MODE_ENTER, 10'h2aa);
        send_request(lfa_pkg::MODE_LEAVE, 10'd1023);  // stale entry, room now held by another
        send_request(lfa_pkg::MODE_LEAVE, 10'd4);
        send_request(lfa_pkg::MODE_ENTER, 10'd1022);

        // fill toward all rooms open, then hover around full so enters get refused
        for (int k = 0; k < RANDOM_REQS; k++)
        begin
            p_enter = (book.opened < MAX_ROOMS) ? 85 : 50;
            if (book.known_ids.size() == 0 || $urandom_range(0, 99) < p_enter)
            begin
                mode = lfa_pkg::MODE_ENTER;
                if ($urandom_range(0, 3) == 0)
                    cid = 10'($urandom_range(0, 15));
                else
                    cid = 10'($urandom_range(0, MAX_CUSTOMERS - 1));
            end
            else
            begin
                mode = lfa_pkg::MODE_LEAVE;
                cid = 10'(book.known_ids[$urandom_range(0, book.known_ids.size() - 1)]);
            end
            send_request(mode, cid);
        end
        req_ch.valid <= 1'b0;

        while (book.due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d enters (%0d reused a released room, %0d refused), %0d leaves",
                 book.n_enter, book.n_reuse, book.n_refused, book.n_leave);
        $display("rooms opened %0d of %0d, %0d mismatches", book.opened, MAX_ROOMS,
                 book.errors);
        if (book.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/lfa_pkg.sv
rtl/lfa_ifs.sv
rtl/lfa_ram.sv
rtl/lfa_ctrl.sv
rtl/lfa_dpath.sv
rtl/lowest_free_id_allocator_core.sv
test/lowest_free_id_allocator_core_tb.sv
